// File: src/cfl_pkg.sv
// ============================================================================
// cfl_pkg
// Shared constants, operation codes and interface types for the CFL limiter.
// ============================================================================
package cfl_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CAP_W     = FRAC_BITS + 10;
    localparam int Q_W       = CAP_W + 2;
    localparam int STEP_W    = $clog2(Q_W);
    localparam int OUT_W     = 26;
    localparam int WIDE_W    = 128;

    localparam logic [CAP_W-1:0] CAP_VALUE = CAP_W'(1000) << FRAC_BITS;

    localparam logic [2:0] REG_DENSITY       = 3'd0;
    localparam logic [2:0] REG_VISCOSITY     = 3'd1;
    localparam logic [2:0] REG_HEAT_CAPACITY = 3'd2;
    localparam logic [2:0] REG_CONDUCTIVITY  = 3'd3;

    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_CONV     = 4'd2;
    localparam logic [3:0] OP_DIV      = 4'd3;
    localparam logic [3:0] OP_TAKE     = 4'd4;
    localparam logic [3:0] OP_SQ       = 4'd5;
    localparam logic [3:0] OP_MD_SETUP = 4'd6;
    localparam logic [3:0] OP_MH_SETUP = 4'd7;
    localparam logic [3:0] OP_MUL      = 4'd8;
    localparam logic [3:0] OP_VISC     = 4'd9;
    localparam logic [3:0] OP_THERM    = 4'd10;
    localparam logic [3:0] OP_EMIT     = 4'd11;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] axis;
        logic [1:0] limb;
    } cmd_t;

    typedef struct packed {
        logic visc_zero;
        logic cond_zero;
        logic last;
        logic out_busy;
    } status_t;

endpackage

// File: src/cfl_ctrl.sv
// ============================================================================
// cfl_ctrl
// Sequencer: walks the three axes and their candidate divisions per cell.
// ============================================================================
module cfl_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cfl_pkg::status_t status,
    output cfl_pkg::cmd_t    cmd
);
    import cfl_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CONV  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_TAKE  = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_MDS   = 4'd5;
    localparam logic [3:0] S_MD    = 4'd6;
    localparam logic [3:0] S_VISC  = 4'd7;
    localparam logic [3:0] S_MHS   = 4'd8;
    localparam logic [3:0] S_MH    = 4'd9;
    localparam logic [3:0] S_THERM = 4'd10;
    localparam logic [3:0] S_AXIS  = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;
    localparam logic [3:0] S_SQM   = 4'd13;

    localparam logic [1:0] PH_CONV  = 2'd0;
    localparam logic [1:0] PH_VISC  = 2'd1;
    localparam logic [1:0] PH_THERM = 2'd2;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [1:0]        axis_reg, axis_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_CONV;
            axis_reg  <= 2'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            axis_reg  <= axis_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        cmd.axis   = axis_reg;
        cmd.limb   = cnt_reg[1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    axis_next  = 2'd0;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.op     = OP_CONV;
                phase_next = PH_CONV;
                cnt_next   = STEP_W'(Q_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (cnt_reg == '0)
                    state_next = S_TAKE;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_TAKE:
            begin
                cmd.op = OP_TAKE;
                case (phase_reg)
                    PH_CONV:  state_next = S_SQ;
                    PH_VISC:  state_next = status.cond_zero ? S_AXIS : S_MHS;
                    default:  state_next = S_AXIS;
                endcase
            end
            S_SQ:
            begin
                cmd.op     = OP_SQ;
                cnt_next   = '0;
                state_next = S_SQM;
            end
            S_SQM:
            begin
                cmd.op     = OP_MUL;
                state_next = S_MDS;
            end
            S_MDS:
            begin
                cmd.op     = OP_MD_SETUP;
                cnt_next   = '0;
                state_next = S_MD;
            end
            S_MD:
            begin
                cmd.op = OP_MUL;
                if (cnt_reg == STEP_W'(1))
                begin
                    if (!status.visc_zero)
                        state_next = S_VISC;
                    else if (!status.cond_zero)
                        state_next = S_MHS;
                    else
                        state_next = S_AXIS;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_VISC:
            begin
                cmd.op     = OP_VISC;
                phase_next = PH_VISC;
                cnt_next   = STEP_W'(Q_W - 1);
                state_next = S_DIV;
            end
            S_MHS:
            begin
                cmd.op     = OP_MH_SETUP;
                cnt_next   = '0;
                state_next = S_MH;
            end
            S_MH:
            begin
                cmd.op = OP_MUL;
                if (cnt_reg == STEP_W'(2))
                    state_next = S_THERM;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_THERM:
            begin
                cmd.op     = OP_THERM;
                phase_next = PH_THERM;
                cnt_next   = STEP_W'(Q_W - 1);
                state_next = S_DIV;
            end
            S_AXIS:
            begin
                if (axis_reg == 2'd2)
                    state_next = status.last ? S_EMIT : S_IDLE;
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_CONV;
                end
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/cfl_datapath.sv
// ============================================================================
// cfl_datapath
// Cell registers, shared 32x32 multiply-accumulate, restoring divider and
// running minimum.
// ============================================================================
module cfl_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  cfl_pkg::cmd_t     cmd,
    output cfl_pkg::status_t  status,
    input  logic [287:0]      in_data,
    input  logic              in_last,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [cfl_pkg::OUT_W-1:0] out_data
);
    import cfl_pkg::*;

    logic [31:0]       w_reg [3];
    logic [31:0]       vlo_reg [3];
    logic [31:0]       vhi_reg [3];
    logic              last_reg;
    logic [31:0]       dens_reg, visc_reg, hc_reg, cond_reg;
    logic [WIDE_W-1:0] acc_reg, rem_reg, dsh_reg;
    logic [95:0]       mula_reg;
    logic [31:0]       mulb_reg;
    logic [Q_W-1:0]    q_reg;
    logic [CAP_W-1:0]  min_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic [31:0]       w_sel;
    logic signed [32:0] vsum;
    logic [32:0]       vmag;
    logic [32:0]       conv_d;
    logic [63:0]       pp;
    logic              ge;
    logic [CAP_W-1:0]  cand;

    always_comb
    begin
        w_sel  = w_reg[cmd.axis];
        vsum   = 33'(signed'(vlo_reg[cmd.axis])) + 33'(signed'(vhi_reg[cmd.axis]));
        vmag   = vsum[32] ? 33'(-vsum) : 33'(vsum);
        conv_d = (vmag >> 1) + 33'd1;
        pp     = 64'(mula_reg[31:0]) * 64'(mulb_reg);
        ge     = (rem_reg >= dsh_reg);
        cand   = (q_reg > Q_W'(CAP_VALUE)) ? CAP_VALUE : q_reg[CAP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dens_reg      <= 32'd65536;
            visc_reg      <= 32'd65536;
            hc_reg        <= 32'd65536;
            cond_reg      <= 32'd65536;
            min_reg       <= CAP_VALUE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DENSITY:       dens_reg <= cfg_data;
                    REG_VISCOSITY:     visc_reg <= cfg_data;
                    REG_HEAT_CAPACITY: hc_reg   <= cfg_data;
                    REG_CONDUCTIVITY:  cond_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.op == OP_TAKE && cand < min_reg)
                min_reg <= cand;
            if (cmd.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
                min_reg       <= CAP_VALUE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    w_reg[i]   <= in_data[32*i +: 32];
                    vlo_reg[i] <= in_data[96 + 64*i +: 32];
                    vhi_reg[i] <= in_data[128 + 64*i +: 32];
                end
                last_reg <= in_last;
            end
            OP_CONV:
            begin
                rem_reg <= WIDE_W'(w_sel) << FRAC_BITS;
                dsh_reg <= WIDE_W'(conv_d) << (Q_W - 1);
                q_reg   <= '0;
            end
            OP_VISC:
            begin
                rem_reg <= acc_reg;
                dsh_reg <= (WIDE_W'(visc_reg) * WIDE_W'(20)) << (FRAC_BITS + Q_W - 1);
                q_reg   <= '0;
            end
            OP_THERM:
            begin
                rem_reg <= acc_reg;
                dsh_reg <= (WIDE_W'(cond_reg) * WIDE_W'(20)) << (2*FRAC_BITS + Q_W - 1);
                q_reg   <= '0;
            end
            OP_DIV:
            begin
                if (ge)
                    rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[Q_W-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
            end
            OP_SQ:
            begin
                mula_reg <= 96'(w_sel);
                mulb_reg <= w_sel;
                acc_reg  <= '0;
            end
            OP_MD_SETUP:
            begin
                mula_reg <= acc_reg[95:0];
                mulb_reg <= dens_reg;
                acc_reg  <= '0;
            end
            OP_MH_SETUP:
            begin
                mula_reg <= acc_reg[95:0];
                mulb_reg <= hc_reg;
                acc_reg  <= '0;
            end
            OP_MUL:
            begin
                acc_reg  <= acc_reg + (WIDE_W'(pp) << (32 * cmd.limb));
                mula_reg <= mula_reg >> 32;
            end
            OP_EMIT:
            begin
                out_data_reg <= OUT_W'(min_reg);
            end
            default:
            begin
            end
        endcase
    end

    // squaring reuses the MAC: one limb pass after SQ loads w into both operands
    assign status.visc_zero = (visc_reg == '0);
    assign status.cond_zero = (cond_reg == '0);
    assign status.last      = last_reg;
    assign status.out_busy  = out_valid_reg && !out_ready;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;

endmodule

// File: src/cfl_time_step_min_top.sv
// Sequence: each cell is processed axis by axis; viscosity and conductivity limits
// are skipped when those registers are zero. m_tvalid rises after a pass's last cell.
// A new cell is taken only once the previous one is done; the shared 1-bit-per-cycle
// divider sets the pace, and a result still held blocks the next cell.
// Reset: asynchronous active low; registers return to 1.0, minimum to 1000.0.
// ============================================================================
// cfl_time_step_min_top
// Streaming CFL time-step limiter: running minimum over cells, emitted per pass.
// ============================================================================
module cfl_time_step_min_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [287:0] s_tdata,   // width_x, width_y, width_z, u_west, u_east,
                                    // v_south, v_north, w_back, w_front
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // time_step[25:0], zero pad
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import cfl_pkg::*;

    cmd_t             cmd;
    status_t          status;
    logic [OUT_W-1:0] time_step;

    cfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cfl_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (time_step)
    );

    assign m_tdata = 32'(time_step);

endmodule
